// ===== hw/rtl/rpp_pkg.sv =====
package rpp_pkg;

    localparam int PALETTE_ENTRIES = 252;
    localparam int COUNT_BITS      = 24;
    localparam int ADDR_BITS       = 8;
    localparam int SUM_BITS        = 32;
    localparam int QUO_CNT_BITS    = $clog2(SUM_BITS);

    localparam logic [1:0] MODE_CONVERT = 2'd0;
    localparam logic [1:0] MODE_QUERY   = 2'd1;
    localparam logic [1:0] MODE_CLEAR   = 2'd2;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEPTH      = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SLOT_BYTES = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BIG_ENDIAN = 2'd2;

    localparam logic [5:0] DEPTH_RESET = 6'd24;
    localparam logic [2:0] SLOT_RESET  = 3'd4;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] entry_index;
    } in_t;

    typedef struct packed {
        logic [31:0] packed_bytes;
        logic [2:0]  byte_count;
        logic [15:0] avg_red;
        logic [15:0] avg_green;
        logic [15:0] avg_blue;
        logic        entry_used;
        logic        count_saturated;
    } out_t;

    typedef struct packed {
        logic [SUM_BITS-1:0]   red_sum;
        logic [SUM_BITS-1:0]   green_sum;
        logic [SUM_BITS-1:0]   blue_sum;
        logic [COUNT_BITS-1:0] count;
    } stats_entry_t;

    typedef struct packed {
        logic [5:0] depth;
        logic [2:0] slot_bytes;
        logic       big_endian;
    } cfg_t;

    function automatic logic [7:0] palette_index(input logic [7:0] r, input logic [7:0] g,
                                                 input logic [7:0] b);
        logic [10:0] gp;
        logic [10:0] rp;
        logic [10:0] bp;
        logic [7:0]  gq;
        logic [7:0]  rq;
        logic [7:0]  bq;
        gp = 11'd7 * {3'b0, g};
        rp = 11'd6 * {3'b0, r};
        bp = 11'd6 * {3'b0, b};
        gq = {5'b0, gp[10:8]};
        rq = {5'b0, rp[10:8]};
        bq = {5'b0, bp[10:8]};
        return 8'(gq * 8'd36 + rq * 8'd6 + bq);
    endfunction

endpackage

// ===== hw/rtl/rgb_pixel_pack_palette_stats.sv =====
// Flow: a request is taken in IDLE; the stats read-modify-write and the result happen in READ;
// the result is held in DONE until the output slot is free. A used-entry query passes through DIV
// between READ and DONE (32-step divider, one quotient bit a cycle for each channel).
// in_stall is high in every state but IDLE, so a used-entry query holds the input for the divider run.
// Reset: config to depth 24, slot 4, little endian; statistics read as zero through
// per-entry valid bits, so no clearing pass is needed.
module rgb_pixel_pack_palette_stats (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  rpp_pkg::in_t                      in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output rpp_pkg::out_t                     out_data,
    input  logic                              cfg_we,
    input  logic [rpp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [rpp_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import rpp_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;
    localparam logic [ADDR_BITS:0] ENTRY_LIMIT = (ADDR_BITS+1)'(PALETTE_ENTRIES);

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    cfg_t                 cfg_reg;
    logic [1:0]           mode_reg;
    logic [7:0]           red_reg;
    logic [7:0]           green_reg;
    logic [7:0]           blue_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic                 ent_ok_reg;
    logic                 pal_reg;
    logic [31:0]          packed_reg;
    logic [2:0]           count_reg;
    out_t                 res_reg;
    out_t                 res_next;
    out_t                 out_reg;
    logic                 out_valid_reg;

    logic [31:0]          pk_bytes;
    logic [2:0]           pk_count;
    logic                 pk_pal;
    logic [7:0]           pk_idx;

    logic                 accept;
    logic                 slot_free;
    logic                 rd_en;
    logic [ADDR_BITS-1:0] rd_addr;
    logic                 q_in_range;
    stats_entry_t         ent;
    stats_entry_t         ent_upd;
    logic                 wr_en;
    logic                 clr;
    logic                 sat;
    logic [SUM_BITS:0]    rsum;
    logic [SUM_BITS:0]    gsum;
    logic [SUM_BITS:0]    bsum;
    logic                 div_start;
    logic                 div_done;
    logic [2:0][15:0]     quo;

    rpp_pack u_pack (
        .px           (in_data),
        .cfg          (cfg_reg),
        .packed_bytes (pk_bytes),
        .byte_count   (pk_count),
        .palette      (pk_pal),
        .pal_idx      (pk_idx)
    );

    assign accept     = in_valid && !in_stall;
    assign in_stall   = (state_reg != S_IDLE);
    assign slot_free  = !out_valid_reg || !out_stall;
    assign q_in_range = ({1'b0, in_data.entry_index} < ENTRY_LIMIT);

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = pk_idx[ADDR_BITS-1:0];
        if (accept && in_data.mode == MODE_CONVERT && pk_pal)
            rd_en = 1'b1;
        else if (accept && in_data.mode == MODE_QUERY && q_in_range)
        begin
            rd_en   = 1'b1;
            rd_addr = in_data.entry_index[ADDR_BITS-1:0];
        end
    end

    rpp_stats_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ent),
        .wr_en   (wr_en),
        .wr_addr (addr_reg),
        .wr_data (ent_upd),
        .clr     (clr)
    );

    rpp_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({ent.blue_sum, ent.green_sum, ent.red_sum}),
        .divisor  (ent.count),
        .done     (div_done),
        .quotient (quo)
    );

    always_comb
    begin
        rsum = {1'b0, ent.red_sum} + (SUM_BITS+1)'(red_reg);
        gsum = {1'b0, ent.green_sum} + (SUM_BITS+1)'(green_reg);
        bsum = {1'b0, ent.blue_sum} + (SUM_BITS+1)'(blue_reg);
        sat  = (&ent.count) || rsum[SUM_BITS] || gsum[SUM_BITS] || bsum[SUM_BITS];
        ent_upd.red_sum   = rsum[SUM_BITS-1:0];
        ent_upd.green_sum = gsum[SUM_BITS-1:0];
        ent_upd.blue_sum  = bsum[SUM_BITS-1:0];
        ent_upd.count     = ent.count + 1'b1;
    end

    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        wr_en      = 1'b0;
        clr        = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_READ;
            end
            S_READ:
            begin
                res_next   = '0;
                state_next = S_DONE;
                unique case (mode_reg)
                    MODE_CONVERT:
                    begin
                        res_next.packed_bytes = packed_reg;
                        res_next.byte_count   = count_reg;
                        if (pal_reg)
                        begin
                            res_next.count_saturated = sat;
                            wr_en                    = !sat;
                        end
                    end
                    MODE_QUERY:
                    begin
                        if (ent_ok_reg && ent.count != '0)
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    MODE_CLEAR:
                        clr = 1'b1;
                    default:
                        res_next = '0;
                endcase
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    res_next.entry_used = 1'b1;
                    res_next.avg_red    = quo[0] + {quo[0][7:0], 8'h00};
                    res_next.avg_green  = quo[1] + {quo[1][7:0], 8'h00};
                    res_next.avg_blue   = quo[2] + {quo[2][7:0], 8'h00};
                    state_next          = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg   <= in_data.mode;
            red_reg    <= in_data.red;
            green_reg  <= in_data.green;
            blue_reg   <= in_data.blue;
            addr_reg   <= rd_addr;
            ent_ok_reg <= q_in_range;
            pal_reg    <= pk_pal;
            packed_reg <= pk_bytes;
            count_reg  <= pk_count;
        end
        res_reg <= res_next;
        if (state_reg == S_DONE && slot_free)
            out_reg <= res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            out_valid_reg      <= 1'b0;
            cfg_reg.depth      <= DEPTH_RESET;
            cfg_reg.slot_bytes <= SLOT_RESET;
            cfg_reg.big_endian <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DONE && slot_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_DEPTH:      cfg_reg.depth      <= cfg_data;
                    CFG_SLOT_BYTES: cfg_reg.slot_bytes <= cfg_data[2:0];
                    CFG_BIG_ENDIAN: cfg_reg.big_endian <= cfg_data[0];
                    default:        cfg_reg            <= cfg_reg;
                endcase
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== hw/rtl/rpp_pack.sv =====
module rpp_pack (
    input  rpp_pkg::in_t      px,
    input  rpp_pkg::cfg_t     cfg,
    output logic [31:0]       packed_bytes,
    output logic [2:0]        byte_count,
    output logic              palette,
    output logic [7:0]        pal_idx
);
    import rpp_pkg::*;

    logic [2:0] slot;
    logic [7:0] lo;
    logic [7:0] hi;

    always_comb
    begin
        if (cfg.slot_bytes < 3'd3)
            slot = 3'd3;
        else if (cfg.slot_bytes > 3'd4)
            slot = 3'd4;
        else
            slot = cfg.slot_bytes;

        if (cfg.depth == 6'd16)
        begin
            lo = {px.green[4:2], px.blue[7:3]};
            hi = {px.red[7:3], px.green[7:5]};
        end
        else
        begin
            lo = {px.green[5:3], px.blue[7:3]};
            hi = {1'b0, px.red[7:3], px.green[7:6]};
        end

        pal_idx = palette_index(px.red, px.green, px.blue);
        palette = 1'b0;

        if (cfg.depth > 6'd16)
        begin
            byte_count = slot;
            if (!cfg.big_endian)
                packed_bytes = {8'h00, px.red, px.green, px.blue};
            else if (slot == 3'd4)
                packed_bytes = {px.blue, px.green, px.red, 8'h00};
            else
                packed_bytes = {8'h00, px.blue, px.green, px.red};
        end
        else if (cfg.depth == 6'd16 || cfg.depth == 6'd15)
        begin
            byte_count   = 3'd2;
            packed_bytes = cfg.big_endian ? {16'h0000, lo, hi} : {16'h0000, hi, lo};
        end
        else
        begin
            byte_count   = 3'd1;
            packed_bytes = {24'h000000, pal_idx};
            palette      = 1'b1;
        end
    end

endmodule

// ===== hw/rtl/rpp_stats_mem.sv =====
module rpp_stats_mem (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [rpp_pkg::ADDR_BITS-1:0] rd_addr,
    output rpp_pkg::stats_entry_t         rd_data,
    input  logic                          wr_en,
    input  logic [rpp_pkg::ADDR_BITS-1:0] wr_addr,
    input  rpp_pkg::stats_entry_t         wr_data,
    input  logic                          clr
);
    import rpp_pkg::*;

    stats_entry_t                mem [PALETTE_ENTRIES];
    stats_entry_t                mem_q_reg;
    logic [PALETTE_ENTRIES-1:0]  valid_reg;
    logic [PALETTE_ENTRIES-1:0]  valid_next;
    logic                        rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            mem_q_reg <= mem[rd_addr];
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (clr)
            valid_next = '0;
        else if (wr_en)
            valid_next[wr_addr] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (rd_en)
                rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? mem_q_reg : '0;

endmodule

// ===== hw/rtl/rpp_divider.sv =====
module rpp_divider (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [2:0][rpp_pkg::SUM_BITS-1:0]   dividend,
    input  logic [rpp_pkg::COUNT_BITS-1:0]      divisor,
    output logic                                done,
    output logic [2:0][15:0]                    quotient
);
    import rpp_pkg::*;

    logic [2:0][SUM_BITS-1:0]   quo_reg;
    logic [2:0][SUM_BITS-1:0]   quo_next;
    logic [2:0][COUNT_BITS-1:0] rem_reg;
    logic [2:0][COUNT_BITS-1:0] rem_next;
    logic [COUNT_BITS-1:0]      dvs_reg;
    logic [QUO_CNT_BITS-1:0]    cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;

    always_comb
    begin
        logic [COUNT_BITS:0] shifted;
        logic [COUNT_BITS:0] diff;
        quo_next = quo_reg;
        rem_next = rem_reg;
        for (int i = 0; i < 3; i++)
        begin
            shifted = {rem_reg[i], quo_reg[i][SUM_BITS-1]};
            diff    = shifted - {1'b0, dvs_reg};
            if (!diff[COUNT_BITS])
            begin
                rem_next[i] = diff[COUNT_BITS-1:0];
                quo_next[i] = {quo_reg[i][SUM_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = shifted[COUNT_BITS-1:0];
                quo_next[i] = {quo_reg[i][SUM_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == QUO_CNT_BITS'(SUM_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            quotient[i] = quo_reg[i][15:0];
    end

endmodule

// ===== hw/rtl/rpp_checker.sv =====
module rpp_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_stall,
    input rpp_pkg::in_t  in_data,
    input logic          out_valid,
    input logic          out_stall,
    input rpp_pkg::out_t out_data
);
    import rpp_pkg::*;

    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while a request is in progress");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.entry_used |->
            out_data.avg_red == 16'h0 && out_data.avg_green == 16'h0 &&
            out_data.avg_blue == 16'h0)
        else $error("average given for an unused entry");

    a_sat_palette: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.count_saturated |->
            out_data.byte_count == 3'd1 && !out_data.entry_used)
        else $error("saturation flag outside palette conversion");

    a_convert_no_avg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.byte_count != 3'd0 |-> !out_data.entry_used)
        else $error("conversion result marks an entry used");

endmodule

bind rgb_pixel_pack_palette_stats rpp_checker u_rpp_checker (.*);
